[sv/assert_macros.svh]
// Assertion macros shared by the vertex screen projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VSP_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VSP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VSP_ASSERT(name, clk, rstn, prop, msg)
`define VSP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

[sv/vsp_pkg.sv]
// Types, widths, register codes and reset values of the vertex screen projection.
package vsp_pkg;

  localparam int unsigned CoordW     = 16;
  localparam int unsigned CoefW      = 16;
  localparam int unsigned ProdW      = 32;
  localparam int unsigned BiasW      = 17;
  localparam int unsigned ModelW     = 34;
  localparam int unsigned ProjW      = 50;
  localparam int unsigned SizeW      = 14;
  localparam int unsigned ScaleW     = 65;
  localparam int unsigned ScreenW    = 16;
  localparam int unsigned CfgW       = 48;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned FracShift  = 14;
  localparam int unsigned ProjDropW  = 36;

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [BiasW-1:0]   bias_t;
  typedef logic signed [ModelW-1:0]  model_t;
  typedef logic signed [ProjW-1:0]   proj_t;
  typedef logic        [SizeW-1:0]   size_t;
  typedef logic signed [ScaleW-1:0]  scale_t;
  typedef logic signed [ScreenW-1:0] screen_t;
  typedef logic        [CfgW-1:0]    cfg_word_t;
  typedef logic        [CfgIdxW-1:0] cfg_idx_t;

  typedef struct packed {
    coef_t [2:0][2:0] rot;
    coord_t [2:0]     pos;
    coord_t [1:0]     off;
    coef_t            shear;
    coef_t            scale_x;
    coef_t            scale_y;
    size_t            width;
    size_t            height;
    logic             apply;
  } vsp_cfg_t;

  localparam cfg_idx_t RegModelRowX    = 3'd0;
  localparam cfg_idx_t RegModelRowY    = 3'd1;
  localparam cfg_idx_t RegModelRowZ    = 3'd2;
  localparam cfg_idx_t RegModelPos     = 3'd3;
  localparam cfg_idx_t RegProjTerms    = 3'd4;
  localparam cfg_idx_t RegOffsetTerms  = 3'd5;
  localparam cfg_idx_t RegViewportSize = 3'd6;
  localparam cfg_idx_t RegApplyModel   = 3'd7;

  localparam cfg_word_t RstModelRowX    = 48'h0000_0000_4000;
  localparam cfg_word_t RstModelRowY    = 48'h0000_4000_0000;
  localparam cfg_word_t RstModelRowZ    = 48'h4000_0000_0000;
  localparam logic [27:0] RstViewport   = 28'd6553700;

endpackage

[sv/vsp_vertex_if.sv]
// Vertex input channel: valid/ready handshake with a Q2.14 vertex.
interface vsp_vertex_if
  import vsp_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t vertex_z;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                  output ready);
endinterface

[sv/vsp_screen_if.sv]
// Screen point output channel: valid/ready handshake with a Q12.4 point.
interface vsp_screen_if
  import vsp_pkg::*;
;
  logic    valid;
  logic    ready;
  screen_t screen_x;
  screen_t screen_y;
  logic    clipped;

  modport source (output valid, output screen_x, output screen_y, output clipped,
                  input ready);
  modport sink   (input valid, input screen_x, input screen_y, input clipped,
                  output ready);
endinterface

[sv/vertex_screen_projection.sv]
// Top level of the vertex screen projection: registers and stage chain.
//
// Vertices enter on vtx_i (valid/ready, Q2.14 x, y, z) and screen points leave
// on scr_o (valid/ready, Q12.4 x, y and a clipped flag), one point per vertex,
// in order. Configuration is written through cfg_we_i / cfg_index_i /
// cfg_data_i; write it only while no vertex is in flight.
// The chain has six register stages: model products, model sums, projection
// products, projection sums, viewport products, rounding and saturation.
// Throughput is one vertex per cycle while the receiver does not stall.
// The last stage is the output register.
// When the receiver stalls, the whole chain holds and vtx_i.ready drops until
// the waiting point is taken or the output stage is empty; nothing is lost.
// Reset clears all stage valid bits and loads the identity model, zero
// position, offsets and projection terms, a 100 x 400 viewport and model mode.
`include "assert_macros.svh"
module vertex_screen_projection
  import vsp_pkg::*;
#(
  parameter int unsigned VIEW_EXTENT_SHIFT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_idx_t    cfg_index_i,
  input  cfg_word_t   cfg_data_i,
  vsp_vertex_if.sink  vtx_i,
  vsp_screen_if.source scr_o
);

  cfg_word_t   model_row_q [3];
  cfg_word_t   model_position_q;
  cfg_word_t   projection_terms_q;
  logic [31:0] offset_terms_q;
  logic [27:0] viewport_size_q;
  logic        apply_model_q;

  vsp_cfg_t     cfg;
  logic         en;
  coord_t [2:0] vtx;
  logic         m_valid, p_valid;
  model_t [2:0] m;
  proj_t        px, py;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_row_q[0]     <= RstModelRowX;
      model_row_q[1]     <= RstModelRowY;
      model_row_q[2]     <= RstModelRowZ;
      model_position_q   <= '0;
      projection_terms_q <= '0;
      offset_terms_q     <= '0;
      viewport_size_q    <= RstViewport;
      apply_model_q      <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegModelRowX:    model_row_q[0]     <= cfg_data_i;
        RegModelRowY:    model_row_q[1]     <= cfg_data_i;
        RegModelRowZ:    model_row_q[2]     <= cfg_data_i;
        RegModelPos:     model_position_q   <= cfg_data_i;
        RegProjTerms:    projection_terms_q <= cfg_data_i;
        RegOffsetTerms:  offset_terms_q     <= cfg_data_i[31:0];
        RegViewportSize: viewport_size_q    <= cfg_data_i[27:0];
        RegApplyModel:   apply_model_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cfg.rot[i][j] = model_row_q[i][16*j +: 16];
      end
      cfg.pos[i] = model_position_q[16*i +: 16];
    end
    cfg.off[0]   = offset_terms_q[15:0];
    cfg.off[1]   = offset_terms_q[31:16];
    cfg.shear    = projection_terms_q[15:0];
    cfg.scale_x  = projection_terms_q[31:16];
    cfg.scale_y  = projection_terms_q[47:32];
    cfg.width    = viewport_size_q[13:0];
    cfg.height   = viewport_size_q[27:14];
    cfg.apply    = apply_model_q;
  end

  assign en          = !scr_o.valid || scr_o.ready;
  assign vtx_i.ready = en;
  assign vtx[0]      = vtx_i.vertex_x;
  assign vtx[1]      = vtx_i.vertex_y;
  assign vtx[2]      = vtx_i.vertex_z;

  vsp_model u_model (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vtx_i.valid),
    .vtx_i   (vtx),
    .cfg_i   (cfg),
    .valid_o (m_valid),
    .m_o     (m)
  );

  vsp_project u_project (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid),
    .m_i     (m),
    .cfg_i   (cfg),
    .valid_o (p_valid),
    .px_o    (px),
    .py_o    (py)
  );

  vsp_screen #(
    .ViewShift (VIEW_EXTENT_SHIFT)
  ) u_screen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (p_valid),
    .px_i       (px),
    .py_i       (py),
    .cfg_i      (cfg),
    .valid_o    (scr_o.valid),
    .screen_x_o (scr_o.screen_x),
    .screen_y_o (scr_o.screen_y),
    .clipped_o  (scr_o.clipped)
  );

  `VSP_ASSERT(a_stall_blocks_input, clk_i, rst_ni, scr_o.valid && !scr_o.ready |-> !vtx_i.ready, "vertex taken while output stalled")

endmodule

[sv/vsp_model.sv]
// Model stages: matrix products, then row sums with position and offsets.
`include "assert_macros.svh"
module vsp_model
  import vsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  coord_t [2:0] vtx_i,
  input  vsp_cfg_t     cfg_i,
  output logic         valid_o,
  output model_t [2:0] m_o
);

  logic   valid1_q, valid2_q;
  prod_t  prod_d [3][3];
  prod_t  prod_q [3][3];
  bias_t  bias_d [3];
  bias_t  bias_q [3];
  coord_t vtx_q  [3];
  model_t m_d    [3];
  model_t m_q    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = prod_t'($signed(cfg_i.rot[i][j])) * prod_t'(vtx_i[j]);
      end
    end
    bias_d[0] = bias_t'($signed(cfg_i.pos[0])) + bias_t'($signed(cfg_i.off[0]));
    bias_d[1] = bias_t'($signed(cfg_i.pos[1])) + bias_t'($signed(cfg_i.off[1]));
    bias_d[2] = bias_t'($signed(cfg_i.pos[2]));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg_i.apply) begin
        m_d[i] = model_t'(prod_q[i][0]) + model_t'(prod_q[i][1]) + model_t'(prod_q[i][2])
               + (model_t'(bias_q[i]) <<< FracShift);
      end else begin
        m_d[i] = model_t'(vtx_q[i]) <<< FracShift;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      bias_q <= bias_d;
      for (int i = 0; i < 3; i++) begin
        vtx_q[i] <= vtx_i[i];
      end
      m_q <= m_d;
    end
  end

  assign valid_o = valid2_q;
  assign m_o[0]  = m_q[0];
  assign m_o[1]  = m_q[1];
  assign m_o[2]  = m_q[2];

  `VSP_ASSERT(a_model_advance, clk_i, rst_ni, en_i |=> (valid2_q == $past(valid1_q)), "model stage valid lost")
  `VSP_ASSERT(a_model_hold, clk_i, rst_ni, !en_i |=> $stable(valid1_q) && $stable(valid2_q), "model stage valid moved during stall")

endmodule

[sv/vsp_project.sv]
// Projection stages: shear and scale products, then projected x/y sums.
module vsp_project
  import vsp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  model_t [2:0] m_i,
  input  vsp_cfg_t     cfg_i,
  output logic         valid_o,
  output proj_t        px_o,
  output proj_t        py_o
);

  logic   valid3_q, valid4_q;
  proj_t  shear_q, sx_q, sy_q;
  model_t m0_q, m1_q;
  proj_t  px_q, py_q;
  proj_t  px_d, py_d;

  assign px_d = (proj_t'(m0_q) <<< FracShift) + shear_q + sx_q;
  assign py_d = (proj_t'(m1_q) <<< FracShift) + sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else if (en_i) begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      shear_q <= proj_t'($signed(cfg_i.shear)) * proj_t'(m_i[1]);
      sx_q    <= proj_t'($signed(cfg_i.scale_x)) * proj_t'(m_i[2]);
      sy_q    <= proj_t'($signed(cfg_i.scale_y)) * proj_t'(m_i[2]);
      m0_q    <= m_i[0];
      m1_q    <= m_i[1];
      px_q    <= px_d;
      py_q    <= py_d;
    end
  end

  assign valid_o = valid4_q;
  assign px_o    = px_q;
  assign py_o    = py_q;

endmodule

[sv/vsp_screen.sv]
// Screen stages: viewport scaling, rounding, centering and saturation.
`include "assert_macros.svh"
module vsp_screen
  import vsp_pkg::*;
#(
  parameter int unsigned ViewShift = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  proj_t    px_i,
  input  proj_t    py_i,
  input  vsp_cfg_t cfg_i,
  output logic     valid_o,
  output screen_t  screen_x_o,
  output screen_t  screen_y_o,
  output logic     clipped_o
);

  localparam int unsigned Drop = ProjDropW + ViewShift;
  localparam int unsigned RndW = ScaleW - Drop;
  localparam int unsigned SumW = RndW + 1;
  localparam scale_t Half = scale_t'(1) <<< (Drop - 1);
  localparam logic signed [SumW-1:0] SatHi = SumW'(32767);
  localparam logic signed [SumW-1:0] SatLo = -SumW'(32768);

  typedef logic signed [SumW-1:0] sum_t;

  logic    valid5_q, valid6_q;
  scale_t  tx_q, ty_q;
  size_t   w_q, h_q;
  sum_t    qx, qy;
  screen_t sx_d, sy_d, sx_q, sy_q;
  logic    cx, cy, clip_q;

  function automatic sum_t place(scale_t t, size_t size);
    scale_t                  r;
    logic signed [RndW-1:0]  q;
    logic        [SizeW+3:0] ctr;
    r   = t + Half;
    q   = r[ScaleW-1:Drop];
    ctr = {1'b0, size[SizeW-1:1], 4'b0000};
    return sum_t'(q) + sum_t'($signed({1'b0, ctr}));
  endfunction

  always_comb begin
    qx = place(tx_q, w_q);
    qy = place(ty_q, h_q);
    cx = (qx > SatHi) || (qx < SatLo);
    cy = (qy > SatHi) || (qy < SatLo);
    if (qx > SatHi)      sx_d = screen_t'(SatHi);
    else if (qx < SatLo) sx_d = screen_t'(SatLo);
    else                 sx_d = screen_t'(qx);
    if (qy > SatHi)      sy_d = screen_t'(SatHi);
    else if (qy < SatLo) sy_d = screen_t'(SatLo);
    else                 sy_d = screen_t'(qy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid5_q <= 1'b0;
      valid6_q <= 1'b0;
    end else if (en_i) begin
      valid5_q <= valid_i;
      valid6_q <= valid5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx_q   <= scale_t'(px_i) * scale_t'({1'b0, cfg_i.width});
      ty_q   <= scale_t'(py_i) * scale_t'({1'b0, cfg_i.height});
      w_q    <= cfg_i.width;
      h_q    <= cfg_i.height;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      clip_q <= cx || cy;
    end
  end

  assign valid_o    = valid6_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign clipped_o  = clip_q;

  `VSP_ASSERT(a_clip_at_bound, clk_i, rst_ni, valid6_q && clip_q |-> (sx_q == 16'sh7fff) || (sx_q == -16'sh8000) || (sy_q == 16'sh7fff) || (sy_q == -16'sh8000), "clipped without a saturated coordinate")
  `VSP_ASSERT(a_screen_hold, clk_i, rst_ni, !en_i |=> $stable(sx_q) && $stable(sy_q) && $stable(clip_q), "screen result changed during stall")

endmodule
